[rtl/longest_common_subsequence_top_defines.svh]
// assertion macros shared by the checker
`ifndef LONGEST_COMMON_SUBSEQUENCE_TOP_DEFINES_SVH
`define LONGEST_COMMON_SUBSEQUENCE_TOP_DEFINES_SVH

// implication checked on every clock edge outside reset
`define LCS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication checked outside reset
`define LCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/lcs_pkg.sv]
package lcs_pkg;

	localparam int MaxLen = 32;
	localparam int LenW = $clog2(MaxLen + 1);
	localparam int IdxW = (MaxLen > 1) ? $clog2(MaxLen) : 1;
	localparam int DirDepth = MaxLen * MaxLen;
	localparam int DirAw = (DirDepth > 1) ? $clog2(DirDepth) : 1;
	localparam int QDepth = 4;
	localparam int QAw = $clog2(QDepth);

	typedef enum logic [1:0] {
		FUNC_APPEND_A = 2'd0,
		FUNC_APPEND_B = 2'd1,
		FUNC_RUN      = 2'd2,
		FUNC_NONE     = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		DIR_DIAG = 2'd0,
		DIR_UP   = 2'd1,
		DIR_LEFT = 2'd2
	} dir_t;

	// classified command handed from front to back
	typedef struct packed {
		func_t      func;
		logic [7:0] symbol;
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_RD,
		ST_FILL,
		ST_TB_RD,
		ST_TB_WAIT,
		ST_TB_STEP,
		ST_EMIT,
		ST_FINAL
	} state_t;

endpackage

[rtl/lcs_front.sv]
module lcs_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    func,
	input  logic [7:0]    symbol,
	output lcs_pkg::cmd_t q_data,
	output logic          q_valid,
	input  logic          q_pop
);
	import lcs_pkg::*;

	cmd_t           mem_q [QDepth];
	logic [QAw-1:0] wr_q;
	logic [QAw-1:0] rd_q;
	logic [QAw:0]   cnt_q;
	logic           push;
	logic           pop;

	// unused func code is dropped here and never queued
	assign in_ready = (cnt_q != (QAw+1)'(QDepth));
	assign push = in_valid && in_ready && (func != FUNC_NONE);
	assign pop = q_pop && q_valid;
	assign q_valid = (cnt_q != '0);
	assign q_data = mem_q[rd_q];

	// command queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= '{func: func_t'(func), symbol: symbol};
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QAw+1)'(push) - (QAw+1)'(pop);
		end
	end
endmodule

[rtl/lcs_back.sv]
module lcs_back (
	input  logic          clk,
	input  logic          arst_n,
	input  lcs_pkg::cmd_t q_data,
	input  logic          q_valid,
	output logic          q_pop,
	output logic [7:0]    symbol_out,
	output logic          symbol_valid,
	output logic [5:0]    lcs_length,
	output logic          overflowed,
	output logic          last,
	output logic          out_valid,
	input  logic          out_ready
);
	import lcs_pkg::*;

	state_t state_q, state_d;

	logic [7:0]      str_a [MaxLen];
	logic [7:0]      str_b [MaxLen];
	logic [1:0]      dir_mem [DirDepth];
	// score of column j is kept at entry j-1; column zero is always zero
	logic [LenW-1:0] row_q [MaxLen];
	logic [7:0]      found_mem [MaxLen];

	logic [LenW-1:0] len_a_q, len_b_q, n_q, m_q;
	logic            ovf_q;
	logic [LenW-1:0] i_q, j_q, k_q, res_len_q;
	logic [LenW-1:0] diag_q;
	logic [7:0]      a_s1, b_s1;
	logic [1:0]      dir_rd_q;
	logic [7:0]      sym_rd_q;
	logic [7:0]      found_rd_q;
	logic            ovf_run_q;

	// output register
	logic            ov_q;
	logic [7:0]      o_sym_q;
	logic            o_sv_q, o_last_q, o_ovf_q;
	logic [5:0]      o_len_q;
	logic            out_free;
	logic            emit_fire;

	logic            load_cmd;
	logic [LenW-1:0] up, left, val;
	dir_t            dir;
	logic            at_end;
	logic [DirAw-1:0] fill_addr, tb_addr;

	assign out_free = !ov_q || out_ready;
	assign emit_fire = out_free && (state_q == ST_EMIT || state_q == ST_FINAL);
	assign out_valid = ov_q;
	assign symbol_out = o_sym_q;
	assign symbol_valid = o_sv_q;
	assign lcs_length = o_len_q;
	assign overflowed = o_ovf_q;
	assign last = o_last_q;

	assign load_cmd = (state_q == ST_IDLE) && q_valid && (q_data.func != FUNC_RUN);

	// cell score
	assign up = row_q[IdxW'(j_q - 1'b1)];
	assign left = (j_q == LenW'(1)) ? '0 : row_q[IdxW'(j_q - LenW'(2))];
	always_comb begin
		if (a_s1 == b_s1) begin
			val = diag_q + 1'b1;
			dir = DIR_DIAG;
		end else if (up >= left) begin
			val = up;
			dir = DIR_UP;
		end else begin
			val = left;
			dir = DIR_LEFT;
		end
	end
	assign at_end = (j_q == m_q);
	assign fill_addr = DirAw'((i_q - 1'b1) * MaxLen + (j_q - 1'b1));
	assign tb_addr = fill_addr;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (q_valid && q_data.func == FUNC_RUN) state_d = ST_CLEAR;
			ST_CLEAR: state_d = (n_q == '0 || m_q == '0) ? ST_TB_STEP : ST_RD;
			ST_RD: state_d = ST_FILL;
			ST_FILL: begin
				if (at_end && i_q == n_q) state_d = ST_TB_RD;
				else state_d = ST_RD;
			end
			ST_TB_RD: state_d = ST_TB_WAIT;
			ST_TB_WAIT: state_d = ST_TB_STEP;
			ST_TB_STEP: begin
				if (i_q == '0 && j_q == '0) state_d = (k_q == '0) ? ST_FINAL : ST_EMIT;
				else if (i_q != '0 && j_q != '0) state_d = ST_TB_RD;
			end
			ST_EMIT: if (out_free && k_q == LenW'(1)) state_d = ST_FINAL;
			ST_FINAL: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// queue pop
	always_comb begin
		q_pop = 1'b0;
		unique case (state_q)
			ST_IDLE: q_pop = q_valid;
			default: q_pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// string stores
	always_ff @(posedge clk) begin
		if (load_cmd && q_data.func == FUNC_APPEND_A && len_a_q < LenW'(MaxLen))
			str_a[len_a_q[IdxW-1:0]] <= q_data.symbol;
		if (load_cmd && q_data.func == FUNC_APPEND_B && len_b_q < LenW'(MaxLen))
			str_b[len_b_q[IdxW-1:0]] <= q_data.symbol;
	end

	// operand read for one cell
	always_ff @(posedge clk) begin
		a_s1 <= str_a[IdxW'(i_q - 1'b1)];
		b_s1 <= str_b[IdxW'(j_q - 1'b1)];
		sym_rd_q <= str_a[IdxW'(i_q - 1'b1)];
	end

	// direction memory
	always_ff @(posedge clk) begin
		if (state_q == ST_FILL) dir_mem[fill_addr] <= dir;
		dir_rd_q <= dir_mem[tb_addr];
	end

	// found symbol stack, read ahead of the pop that is taking place
	always_ff @(posedge clk) begin
		if (state_q == ST_TB_STEP && i_q != '0 && j_q != '0 && dir_rd_q == DIR_DIAG)
			found_mem[IdxW'(k_q)] <= sym_rd_q;
		found_rd_q <= found_mem[IdxW'(k_q - ((state_q == ST_EMIT && out_free) ?
			LenW'(2) : LenW'(1)))];
	end

	// score row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < MaxLen; r++) row_q[r] <= '0;
		end else if (state_q == ST_CLEAR) begin
			for (int r = 0; r < MaxLen; r++) row_q[r] <= '0;
		end else if (state_q == ST_FILL) begin
			row_q[IdxW'(j_q - 1'b1)] <= val;
		end
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_a_q <= '0;
			len_b_q <= '0;
			ovf_q <= 1'b0;
			n_q <= '0;
			m_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			diag_q <= '0;
			res_len_q <= '0;
			ovf_run_q <= 1'b0;
			ov_q <= 1'b0;
			o_sym_q <= '0;
			o_sv_q <= 1'b0;
			o_len_q <= '0;
			o_ovf_q <= 1'b0;
			o_last_q <= 1'b0;
		end else begin
			if (emit_fire) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (load_cmd) begin
						if (q_data.func == FUNC_APPEND_A) begin
							if (len_a_q < LenW'(MaxLen)) len_a_q <= len_a_q + 1'b1;
							else ovf_q <= 1'b1;
						end else begin
							if (len_b_q < LenW'(MaxLen)) len_b_q <= len_b_q + 1'b1;
							else ovf_q <= 1'b1;
						end
					end else if (q_valid) begin
						n_q <= len_a_q;
						m_q <= len_b_q;
						i_q <= len_a_q;
						j_q <= len_b_q;
						ovf_run_q <= ovf_q;
						ovf_q <= 1'b0;
						len_a_q <= '0;
						len_b_q <= '0;
					end
				end
				ST_CLEAR: begin
					k_q <= '0;
					res_len_q <= '0;
					diag_q <= '0;
					if (n_q != '0 && m_q != '0) begin
						i_q <= LenW'(1);
						j_q <= LenW'(1);
					end
				end
				ST_FILL: begin
					if (at_end) begin
						if (i_q == n_q) begin
							res_len_q <= val;
							i_q <= n_q;
							j_q <= m_q;
						end else begin
							i_q <= i_q + 1'b1;
							j_q <= LenW'(1);
							diag_q <= '0;
						end
					end else begin
						j_q <= j_q + 1'b1;
						diag_q <= up;
					end
				end
				ST_TB_STEP: begin
					if (i_q == '0) begin
						if (j_q != '0) j_q <= j_q - 1'b1;
					end else if (j_q == '0) begin
						i_q <= i_q - 1'b1;
					end else if (dir_rd_q == DIR_DIAG) begin
						k_q <= k_q + 1'b1;
						i_q <= i_q - 1'b1;
						j_q <= j_q - 1'b1;
					end else if (dir_rd_q == DIR_UP) begin
						i_q <= i_q - 1'b1;
					end else begin
						j_q <= j_q - 1'b1;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						o_sym_q <= found_rd_q;
						o_sv_q <= 1'b1;
						o_len_q <= '0;
						o_ovf_q <= 1'b0;
						o_last_q <= 1'b0;
						k_q <= k_q - 1'b1;
					end
				end
				ST_FINAL: begin
					if (out_free) begin
						o_sym_q <= '0;
						o_sv_q <= 1'b0;
						o_len_q <= 6'(res_len_q);
						o_ovf_q <= ovf_run_q;
						o_last_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end
endmodule

[rtl/longest_common_subsequence_top.sv]
// longest common subsequence engine
// input channel: in_valid/in_ready with func and symbol. func 0 appends
// symbol to the first string, func 1 to the second, func 2 runs, func 3
// is ignored. a load request is taken through a four-entry command queue;
// an append beyond 32 symbols sets a sticky overflow flag.
// output channel: out_valid/out_ready with symbol_out, symbol_valid,
// lcs_length, overflowed and last. a run emits the subsequence symbols in
// forward order, then one item with last set carrying length and overflow.
// a run fills the table cell by cell (a read state, then a fill state)
// through the string and direction memories, then traces back (read,
// wait and step states per inner step, the step state alone along the
// top row or left column), emits the results; the run empties both strings.
// results sit in an output register; while the receiver stalls the
// engine holds and the queue keeps accepting requests until it fills.
// reset clears lengths, scores, the flag and all control state.
module longest_common_subsequence_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] func,
	input  logic [7:0] symbol,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] symbol_out,
	output logic       symbol_valid,
	output logic [5:0] lcs_length,
	output logic       overflowed,
	output logic       last
);
	import lcs_pkg::*;

	cmd_t q_data;
	logic q_valid;
	logic q_pop;

	lcs_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.func(func), .symbol(symbol), .q_data(q_data), .q_valid(q_valid),
		.q_pop(q_pop)
	);

	lcs_back u_back (
		.clk(clk), .arst_n(arst_n), .q_data(q_data), .q_valid(q_valid),
		.q_pop(q_pop), .symbol_out(symbol_out), .symbol_valid(symbol_valid),
		.lcs_length(lcs_length), .overflowed(overflowed), .last(last),
		.out_valid(out_valid), .out_ready(out_ready)
	);
endmodule

[rtl/lcs_checker.sv]
`include "longest_common_subsequence_top_defines.svh"

module lcs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] symbol_out,
	input logic       symbol_valid,
	input logic [5:0] lcs_length,
	input logic       overflowed,
	input logic       last
);
	// a stalled result holds
	`LCS_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(symbol_out) && $stable(last), "stalled result changed")
	// exactly one of symbol and final
	`LCS_ASSERT_IMPL(a_kind, clk, arst_n, out_valid, symbol_valid != last, "result kind ambiguous")
	// symbol items carry no length
	`LCS_ASSERT_IMPL(a_symfields, clk, arst_n, out_valid && symbol_valid, lcs_length == 6'd0 && !overflowed, "symbol item fields")
	// length bounded and no symbol on the final item
	`LCS_ASSERT_IMPL(a_len, clk, arst_n, out_valid && last, lcs_length <= 6'd32 && symbol_out == 8'd0, "final item fields")
endmodule

bind longest_common_subsequence_top lcs_checker u_lcs_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_ready(out_ready),
	.symbol_out(symbol_out), .symbol_valid(symbol_valid), .lcs_length(lcs_length),
	.overflowed(overflowed), .last(last)
);
